### hw/rtl/tournament_branch_predictor_defines.svh
// Assertion macros used by the predictor controller.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define TBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, including while reset is held.
`define TBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/tbp_pkg.sv
package tbp_pkg;

  // Default table sizes.
  localparam int unsigned LhtEntriesDef = 1024;
  localparam int unsigned HistBitsDef   = 12;

  // Packed stream widths.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned AddrW    = 32;

  // Operation codes carried in tuser.
  localparam logic OpPredict = 1'b0;
  localparam logic OpUpdate  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // write one clearing row
    logic ld_in;   // capture item, read history and global-indexed tables
    logic rd_lc;   // read local counter at the fetched history
    logic commit;  // register prediction and train tables
  } tbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pass is on its last row
  } tbp_sts_t;

  // Saturating 2-bit counter step.
  function automatic logic [1:0] sat2(input logic [1:0] v, input logic up);
    logic [1:0] r;
    r = v;
    if (up && v != 2'd3) r = v + 2'd1;
    else if (!up && v != 2'd0) r = v - 2'd1;
    return r;
  endfunction

  // Saturating 3-bit counter step.
  function automatic logic [2:0] sat3(input logic [2:0] v, input logic up);
    logic [2:0] r;
    r = v;
    if (up && v != 3'd7) r = v + 3'd1;
    else if (!up && v != 3'd0) r = v - 3'd1;
    return r;
  endfunction

endpackage

### hw/rtl/tournament_branch_predictor.sv
// Tournament branch predictor: each input item returns one prediction computed from
// the tables as they were before it, and an update item then trains them. The edge
// that accepts an item also reads the local history table and the global-indexed
// counters. The result is presented after the dependent local counter read in
// S_LHT and the commit in S_EVAL. No new item is accepted before the last one is
// committed, as the two dependent reads of the local history table and the local
// counter memory and the commit come in turn. A finished result waits in an output
// register and stalls only the commit of the following item. After reset a clearing
// pass over max(LHT_ENTRIES, 2^HIST_BITS) rows (4096 at the defaults) zeroes all
// tables; no item is accepted until it ends. LHT_ENTRIES must be a power of two.
module tournament_branch_predictor #(
  parameter int unsigned LHT_ENTRIES = tbp_pkg::LhtEntriesDef,
  parameter int unsigned HIST_BITS   = tbp_pkg::HistBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // branch_address [31:0], is_cond [32], outcome_taken [33], zero [39:34]
  input  logic [tbp_pkg::InDataW-1:0]   s_axis_tdata,
  // op [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // predict_taken [0], zero [7:1]
  output logic [tbp_pkg::OutDataW-1:0]  m_axis_tdata
);

  tbp_pkg::tbp_cmd_t cmd;
  tbp_pkg::tbp_sts_t sts;
  logic              pred;

  tbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tbp_datapath #(
    .LHT_ENTRIES (LHT_ENTRIES),
    .HIST_BITS   (HIST_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (s_axis_tuser),
    .branch_address_i (s_axis_tdata[tbp_pkg::AddrW-1:0]),
    .is_cond_i        (s_axis_tdata[tbp_pkg::AddrW]),
    .outcome_taken_i  (s_axis_tdata[tbp_pkg::AddrW+1]),
    .predict_taken_o  (pred)
  );

  assign m_axis_tdata = {{(tbp_pkg::OutDataW-1){1'b0}}, pred};

endmodule

### hw/rtl/tbp_ram.sv
module tbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds without re_i.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tbp_datapath.sv
module tbp_datapath #(
  parameter int unsigned LHT_ENTRIES = tbp_pkg::LhtEntriesDef,
  parameter int unsigned HIST_BITS   = tbp_pkg::HistBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbp_pkg::tbp_cmd_t           cmd_i,
  output tbp_pkg::tbp_sts_t           sts_o,
  input  logic                        op_i,
  input  logic [tbp_pkg::AddrW-1:0]   branch_address_i,
  input  logic                        is_cond_i,
  input  logic                        outcome_taken_i,
  output logic                        predict_taken_o
);

  localparam int unsigned LidxW      = $clog2(LHT_ENTRIES);
  localparam int unsigned PhtEntries = 1 << HIST_BITS;
  localparam int unsigned ClrDepth   = (LHT_ENTRIES > PhtEntries) ? LHT_ENTRIES : PhtEntries;
  localparam int unsigned ClrW       = $clog2(ClrDepth);

  // Item registers.
  logic             op_q;
  logic [LidxW-1:0] lidx_q;
  logic             cond_q;
  logic             taken_q;
  logic             pred_q;

  // Clearing sweep and global history.
  logic [ClrW-1:0]      clr_q, clr_d;
  logic [HIST_BITS-1:0] ghist_q, ghist_d;

  // Table ports.
  logic                 lht_we, lc_we, pht_we;
  logic [LidxW-1:0]     lht_waddr;
  logic [HIST_BITS-1:0] lht_wdata, lht_rdata;
  logic [HIST_BITS-1:0] lc_waddr, pht_waddr;
  logic [2:0]           lc_wdata, lc_rdata;
  logic [3:0]           pht_wdata, pht_rdata;
  logic                 clr_lht, clr_pht;

  // Prediction terms.
  logic local_says, global_says, use_global, pred;
  logic upd, upd_cond;
  logic [1:0] choice_nxt;

  // Capture the item at acceptance; the prediction at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q    <= op_i;
      lidx_q  <= branch_address_i[2 +: LidxW];
      cond_q  <= is_cond_i;
      taken_q <= outcome_taken_i;
    end
    if (cmd_i.commit) begin
      pred_q <= pred;
    end
  end

  // Clear counter and global history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      ghist_q <= '0;
    end else begin
      clr_q   <= clr_d;
      ghist_q <= ghist_d;
    end
  end

  assign clr_d = cmd_i.clr ? clr_q + ClrW'(1) : clr_q;
  assign sts_o.clr_last = (clr_q == ClrW'(ClrDepth - 1));
  assign clr_lht = cmd_i.clr && ({1'b0, clr_q} < (ClrW + 1)'(LHT_ENTRIES));
  assign clr_pht = cmd_i.clr && ({1'b0, clr_q} < (ClrW + 1)'(PhtEntries));

  // Prediction from the tables as they stood before this item.
  assign local_says  = (lc_rdata > 3'd3);
  assign global_says = pht_rdata[1];
  assign use_global  = pht_rdata[3];
  assign pred        = cond_q ? (use_global ? global_says : local_says) : 1'b1;

  // Training.
  assign upd      = cmd_i.commit && (op_q == tbp_pkg::OpUpdate);
  assign upd_cond = upd && cond_q;

  always_comb begin
    choice_nxt = pht_rdata[3:2];
    if (global_says == taken_q && local_says != taken_q) begin
      choice_nxt = tbp_pkg::sat2(pht_rdata[3:2], 1'b1);
    end else if (global_says != taken_q && local_says == taken_q) begin
      choice_nxt = tbp_pkg::sat2(pht_rdata[3:2], 1'b0);
    end
  end

  assign ghist_d = upd_cond ? {ghist_q[HIST_BITS-2:0], taken_q} : ghist_q;

  // Write ports are shared between the clearing sweep and training.
  assign lht_we    = clr_lht || upd;
  assign lht_waddr = cmd_i.clr ? clr_q[LidxW-1:0] : lidx_q;
  assign lht_wdata = cmd_i.clr ? '0 : {lht_rdata[HIST_BITS-2:0], taken_q};

  assign lc_we     = clr_pht || upd_cond;
  assign lc_waddr  = cmd_i.clr ? clr_q[HIST_BITS-1:0] : lht_rdata;
  assign lc_wdata  = cmd_i.clr ? 3'd0 : tbp_pkg::sat3(lc_rdata, taken_q);

  assign pht_we    = clr_pht || upd_cond;
  assign pht_waddr = cmd_i.clr ? clr_q[HIST_BITS-1:0] : ghist_q;
  assign pht_wdata = cmd_i.clr ? 4'd0
                               : {choice_nxt, tbp_pkg::sat2(pht_rdata[1:0], taken_q)};

  // Local history table, indexed by address bits above the word offset.
  tbp_ram #(.WIDTH(HIST_BITS), .DEPTH(LHT_ENTRIES)) u_lht (
    .clk_i   (clk_i),
    .we_i    (lht_we),
    .waddr_i (lht_waddr),
    .wdata_i (lht_wdata),
    .re_i    (cmd_i.ld_in),
    .raddr_i (branch_address_i[2 +: LidxW]),
    .rdata_o (lht_rdata)
  );

  // Local counters, indexed by the fetched local history.
  tbp_ram #(.WIDTH(3), .DEPTH(PhtEntries)) u_lc (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .re_i    (cmd_i.rd_lc),
    .raddr_i (lht_rdata),
    .rdata_o (lc_rdata)
  );

  // Choice and global counters share the global history index: {choice, global}.
  tbp_ram #(.WIDTH(4), .DEPTH(PhtEntries)) u_pht (
    .clk_i   (clk_i),
    .we_i    (pht_we),
    .waddr_i (pht_waddr),
    .wdata_i (pht_wdata),
    .re_i    (cmd_i.ld_in),
    .raddr_i (ghist_q),
    .rdata_o (pht_rdata)
  );

  assign predict_taken_o = pred_q;

endmodule

### hw/rtl/tbp_ctrl.sv
`include "tournament_branch_predictor_defines.svh"

module tbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbp_pkg::tbp_cmd_t cmd_o,
  input  tbp_pkg::tbp_sts_t sts_i
);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LHT  = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // Sequencing: clear sweep, accept, history read, counter read and commit.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_LHT;
        end
      end
      S_LHT: begin
        cmd_o.rd_lc = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // Checks.
  `TBP_ASSERT(a_commit_shows, cmd_o.commit |=> out_valid_q, "commit did not raise out valid")
  `TBP_ASSERT(a_walk, (in_valid_i && in_ready_o) |=> (state_q == S_LHT) ##1 (state_q == S_EVAL), "item did not walk the read states")
  `TBP_ASSERT(a_stall_eval, (state_q == S_EVAL && out_valid_q && !out_ready_i) |=> (state_q == S_EVAL), "result overwrote an untaken one")
  `TBP_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> (state_q == S_CLR && !out_valid_q), "reset did not start the clearing pass")

endmodule

### tb/tournament_branch_predictor_test.sv
module tournament_branch_predictor_test;

  localparam int unsigned LhtEntries = tbp_pkg::LhtEntriesDef;
  localparam int unsigned HistBits   = tbp_pkg::HistBitsDef;
  localparam int unsigned PhtEntries = 1 << HistBits;
  localparam int unsigned PoolSize   = 16;
  localparam int unsigned PhaseItems = 475;
  localparam int unsigned HoldCycles = 300;

  // Shadow copy of the predictor tables and the predictions still owed by the block.
  class prediction_board;
    bit [HistBits-1:0] lht_shadow [LhtEntries];
    bit [2:0]          local_ctr  [PhtEntries];
    bit [1:0]          global_ctr [PhtEntries];
    bit [1:0]          choice_ctr [PhtEntries];
    bit [HistBits-1:0] global_hist;
    bit                expected_taken_q [$];
    int unsigned       mismatches;

    // Works out the prediction of one accepted item, then trains the tables for an update item.
    function void note_branch(logic op, logic [tbp_pkg::AddrW-1:0] addr, logic cond,
                              logic taken);
      int unsigned       lidx;
      bit [HistBits-1:0] lh;
      bit [HistBits-1:0] gh;
      bit                local_says;
      bit                global_says;
      bit                use_global;
      lidx        = (addr >> 2) % LhtEntries;
      lh          = lht_shadow[lidx];
      gh          = global_hist;
      local_says  = local_ctr[lh] > 3'd3;
      global_says = global_ctr[gh] > 2'd1;
      use_global  = choice_ctr[gh] > 2'd1;
      expected_taken_q.push_back(cond ? (use_global ? global_says : local_says) : 1'b1);
      if (op == tbp_pkg::OpUpdate) begin
        if (cond) begin
          // The chooser only moves when exactly one of the two sources was right.
          if (global_says == taken && local_says != taken) begin
            if (choice_ctr[gh] != 2'd3) choice_ctr[gh] = choice_ctr[gh] + 2'd1;
          end else if (global_says != taken && local_says == taken) begin
            if (choice_ctr[gh] != 2'd0) choice_ctr[gh] = choice_ctr[gh] - 2'd1;
          end
          if (taken && global_ctr[gh] != 2'd3) global_ctr[gh] = global_ctr[gh] + 2'd1;
          if (!taken && global_ctr[gh] != 2'd0) global_ctr[gh] = global_ctr[gh] - 2'd1;
          if (taken && local_ctr[lh] != 3'd7) local_ctr[lh] = local_ctr[lh] + 3'd1;
          if (!taken && local_ctr[lh] != 3'd0) local_ctr[lh] = local_ctr[lh] - 3'd1;
          global_hist = {gh[HistBits-2:0], taken};
        end
        lht_shadow[lidx] = {lh[HistBits-2:0], taken};
      end
    endfunction

    // Compares one accepted result with the oldest owed prediction.
    function void check_prediction(logic actual);
      bit want;
      if (expected_taken_q.size() == 0) begin
        $error("predict_taken: expected none, actual %0d", actual);
        mismatches++;
      end else begin
        want = expected_taken_q.pop_front();
        if (actual !== want) begin
          $error("predict_taken: expected %0d, actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_taken_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [tbp_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [tbp_pkg::OutDataW-1:0] m_axis_tdata;

  prediction_board board = new;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;

  // Branch pool: each entry repeats a taken pattern of its own period.
  bit [tbp_pkg::AddrW-1:0] pool_addr   [PoolSize];
  bit                      pool_cond   [PoolSize];
  int unsigned             pool_period [PoolSize];
  int unsigned             pool_pos    [PoolSize];

  tournament_branch_predictor u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watch both handshakes; a new item is noted before a result is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_branch(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[32],
                          s_axis_tdata[33]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_prediction(m_axis_tdata[0]);
      end
    end
  end

  // Offers one item after a random gap and returns at the falling edge after its acceptance.
  task automatic send_branch(logic op, logic [tbp_pkg::AddrW-1:0] addr, logic cond,
                             logic taken);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, taken, cond, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Mostly well-trained pool branches, with some fully random items mixed in.
  task automatic run_phase(int unsigned n, int unsigned src_pct, int unsigned sink_pct,
                           bit with_hold);
    int unsigned k;
    logic        op;
    logic        taken;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (with_hold) hold_req = HoldCycles;
    repeat (n) begin
      if ($urandom_range(99) < 80) begin
        k     = $urandom_range(PoolSize - 1);
        op    = ($urandom_range(99) < 85) ? tbp_pkg::OpUpdate : tbp_pkg::OpPredict;
        taken = (pool_pos[k] != pool_period[k] - 1);
        if ($urandom_range(99) < 5) taken = ~taken;
        if (op == tbp_pkg::OpUpdate) pool_pos[k] = (pool_pos[k] + 1) % pool_period[k];
        send_branch(op, pool_addr[k], pool_cond[k], taken);
      end else begin
        op = $urandom_range(1) ? tbp_pkg::OpUpdate : tbp_pkg::OpPredict;
        send_branch(op, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Time limit for the whole run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tbp_pkg::OpPredict;
    m_axis_tready = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i]   = $urandom;
      pool_cond[i]   = ($urandom_range(99) < 85);
      pool_period[i] = $urandom_range(1, 7);
      pool_pos[i]    = 0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: cleared tables, unconditional branches, address extremes,
    // ignored outcome on predict only, and counters driven into saturation.
    send_branch(tbp_pkg::OpPredict, 32'h0000_0000, 1'b0, 1'b0);
    send_branch(tbp_pkg::OpPredict, 32'h0000_0000, 1'b1, 1'b0);
    send_branch(tbp_pkg::OpPredict, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_branch(tbp_pkg::OpUpdate,  32'hFFFF_FFFF, 1'b0, 1'b1);
    send_branch(tbp_pkg::OpUpdate,  32'hFFFF_FFFC, 1'b0, 1'b0);
    send_branch(tbp_pkg::OpPredict, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_branch(tbp_pkg::OpUpdate,  32'h0000_0000, 1'b1, 1'b0);
    repeat (14) send_branch(tbp_pkg::OpUpdate, 32'h0000_1004, 1'b1, 1'b1);
    send_branch(tbp_pkg::OpPredict, 32'h0000_1004, 1'b1, 1'b0);
    send_branch(tbp_pkg::OpUpdate,  32'h0000_1004, 1'b1, 1'b0);
    send_branch(tbp_pkg::OpUpdate,  32'hAAAA_AAA8, 1'b1, 1'b1);
    send_branch(tbp_pkg::OpUpdate,  32'h5555_5554, 1'b1, 1'b0);

    // Random part over the idling mixes; the first phase includes a long sink hold-off.
    run_phase(PhaseItems, 0, 0, 1'b1);
    run_phase(PhaseItems, 74, 0, 1'b0);
    run_phase(PhaseItems, 0, 74, 1'b0);
    run_phase(PhaseItems, 37, 37, 1'b0);
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
